FILE: rtl/core/csl_pkg.sv
package csl_pkg;

    // Widest cursor the block is built for, and shift/pad count width
    localparam int MAX_CURSOR_SIZE = 64;
    localparam int ROW_W           = 64;
    localparam int POS_W           = 16;
    localparam int SHIFT_W         = $clog2(MAX_CURSOR_SIZE + 1);
    localparam int CFG_IDX_W       = 1;

    // Defaults for the top-level parameters
    localparam int DEF_CURSOR_SIZE = 64;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POS_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 1'b1;

    // One classified row handed from the front to the back
    typedef struct packed {
        logic [ROW_W-1:0]   row;    // shifted source row
        logic               keep;   // the source row itself goes out
        logic               last;   // last input row of a plane
        logic [SHIFT_W-1:0] pad;    // zero rows that follow
    } cmd_t;

    // Occupancy flags of the queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/core/csl_front.sv
module csl_front
    import csl_pkg::*;
#(
    parameter int CURSOR_SIZE = DEF_CURSOR_SIZE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [POS_W-1:0]     wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ROW_W-1:0]     row_bits,
    input  q_stat_t              q_stat,
    output logic                 push,
    output cmd_t                 push_cmd
);

    localparam int CNT_W = $clog2(2 * CURSOR_SIZE);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(2 * CURSOR_SIZE - 1);
    localparam logic [CNT_W-1:0]   CNT_HALF = CNT_W'(CURSOR_SIZE);
    localparam logic [CNT_W-1:0]   LOC_LAST = CNT_W'(CURSOR_SIZE - 1);
    localparam logic [SHIFT_W-1:0] SH_FULL  = SHIFT_W'(CURSOR_SIZE);
    localparam logic [POS_W:0]     NEG_FULL = (POS_W + 1)'(CURSOR_SIZE);

    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] local_idx;
    logic [POS_W:0]   neg_x;
    logic [POS_W:0]   neg_y;
    logic [SHIFT_W-1:0] hs;
    logic [SHIFT_W-1:0] vs_raw;
    logic [SHIFT_W-1:0] vs;
    logic             accept;
    logic             last;
    logic             keep;

    // Position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_POS_X: pos_x_reg <= wr_data;
                REG_POS_Y: pos_y_reg <= wr_data;
                default:   ;
            endcase
        end
    end

    // Clip shifts: minus a negative position (else zero), capped at the cursor size
    always_comb
    begin
        neg_x = (POS_W + 1)'(0) - {pos_x_reg[POS_W-1], pos_x_reg};
        neg_y = (POS_W + 1)'(0) - {pos_y_reg[POS_W-1], pos_y_reg};
        if (!pos_x_reg[POS_W-1])
            hs = '0;
        else if (neg_x >= NEG_FULL)
            hs = SH_FULL;
        else
            hs = neg_x[SHIFT_W-1:0];
        if (!pos_y_reg[POS_W-1])
            vs_raw = '0;
        else if (neg_y >= NEG_FULL)
            vs_raw = SH_FULL;
        else
            vs_raw = neg_y[SHIFT_W-1:0];
        vs = (hs == SH_FULL || vs_raw == SH_FULL) ? SH_FULL : vs_raw;
    end

    // Classify the word against the plane-local row index
    always_comb
    begin
        local_idx = (cnt_reg < CNT_HALF) ? cnt_reg : cnt_reg - CNT_HALF;
        last      = (local_idx == LOC_LAST);
        keep      = (32'(local_idx) >= 32'(vs));
        in_stall  = q_stat.full;
        accept    = in_valid && !in_stall;
        push      = accept && (keep || last);
        push_cmd.row  = (hs >= SHIFT_W'(ROW_W)) ? '0 : (row_bits << hs);
        push_cmd.keep = keep;
        push_cmd.last = last;
        push_cmd.pad  = last ? vs : '0;
        cnt_next  = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CNT_W'(1);
    end

    // Advance the row counter on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

endmodule

FILE: rtl/core/csl_queue.sv
module csl_queue
    import csl_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Hold the entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_stat.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

endmodule

FILE: rtl/core/csl_back.sv
module csl_back
    import csl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             head,
    input  q_stat_t          q_stat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ROW_W-1:0] out_row,
    output logic             run_end,
    output logic             plane_end
);

    logic               row_done_reg;
    logic [SHIFT_W-1:0] pad_cnt_reg;
    logic               send_row;
    logic               is_last;
    logic               take;

    // Source row first, then the zero padding rows
    always_comb
    begin
        out_valid = !q_stat.empty;
        send_row  = head.keep && !row_done_reg;
        if (send_row)
            is_last = (head.pad == '0);
        else
            is_last = (pad_cnt_reg == head.pad - SHIFT_W'(1));
        out_row   = send_row ? head.row : '0;
        run_end   = is_last;
        plane_end = is_last && head.last;
        take      = out_valid && !out_stall;
        pop       = take && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_done_reg <= 1'b0;
            pad_cnt_reg  <= '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                row_done_reg <= 1'b0;
                pad_cnt_reg  <= '0;
            end
            else if (send_row)
                row_done_reg <= 1'b1;
            else
                pad_cnt_reg <= pad_cnt_reg + SHIFT_W'(1);
        end
    end

    a_pad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_row) |-> (pad_cnt_reg < head.pad))
        else $error("padding row beyond the command's count");

    a_plane_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && plane_end) |-> (pop == !out_stall))
        else $error("plane end on a word that does not retire its command");

endmodule

FILE: rtl/core/cursor_image_clip_shift_loader.sv
// Channel   Direction  Handshake            Payload
// config    in         wr_en                wr_index, wr_data (pos_x, pos_y)
// source    in         in_valid / in_stall  row_bits
// result    out        out_valid/out_stall  out_row, run_end, plane_end
//
// One source word is taken per cycle while the command queue has room.
// A kept row leaves in the cycle after acceptance at the earliest; the last
// row of a plane is followed by its padding rows, counted by the back's pad counter.
// Reset clears the positions, the row counter, the queue and the back.
// A stalled result backs up into the queue and then stalls the source.
module cursor_image_clip_shift_loader
    import csl_pkg::*;
#(
    parameter int CURSOR_SIZE = DEF_CURSOR_SIZE,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [POS_W-1:0]     wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ROW_W-1:0]     row_bits,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     out_row,
    output logic                 run_end,
    output logic                 plane_end
);

    cmd_t    push_cmd;
    cmd_t    head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    csl_front #(
        .CURSOR_SIZE (CURSOR_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .row_bits (row_bits),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    csl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    csl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .run_end   (run_end),
        .plane_end (plane_end)
    );

endmodule

FILE: verif/cursor_image_clip_shift_loader_tb.sv
module cursor_image_clip_shift_loader_tb;
    import csl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CSIZE         = DEF_CURSOR_SIZE;
    localparam int ROW_TARGET    = 450;
    localparam int DIRECTED_ROWS = 70;
    localparam int RANDOM_QUOTA  = (ROW_TARGET - DIRECTED_ROWS) / 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYC    = 12;
    localparam int MAX_PRINTS    = 60;

    // One row written to cursor memory
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             run_end;
        logic             plane_end;
    } mem_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [POS_W-1:0]     wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [ROW_W-1:0]     row_bits;
    logic                 out_valid;
    logic                 out_stall;
    logic [ROW_W-1:0]     out_row;
    logic                 run_end;
    logic                 plane_end;

    // Predictor state: positions and the running source row index
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    int unsigned             src_row_idx;
    mem_row_t                pending_rows[$];

    int unsigned err_cnt;
    int unsigned rows_sent;
    int unsigned cycle_cnt;
    int unsigned src_idle_pct;
    int unsigned dst_stall_pct;
    int unsigned hold_req;
    int unsigned hold_left;

    cursor_image_clip_shift_loader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .row_bits  (row_bits),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .run_end   (run_end),
        .plane_end (plane_end)
    );

    // Free-running clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive the receiver stall: a requested long hold wins over random stalls
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                   input logic [ROW_W-1:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("tb: mismatch on %s at cycle %0d: got %h want %h",
                     what, cycle_cnt, got, want);
        err_cnt++;
    endtask

    // Compare each accepted result word against the oldest expected row
    always @(posedge clk)
    begin
        mem_row_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rows.size() == 0)
                report_mismatch("unexpected word", out_row, '0);
            else
            begin
                want = pending_rows.pop_front();
                if (out_row !== want.row)
                    report_mismatch("out_row", out_row, want.row);
                if (run_end !== want.run_end)
                    report_mismatch("run_end", ROW_W'(run_end), ROW_W'(want.run_end));
                if (plane_end !== want.plane_end)
                    report_mismatch("plane_end", ROW_W'(plane_end), ROW_W'(want.plane_end));
            end
        end
    end

    function automatic int unsigned clip_amount(input logic signed [POS_W-1:0] p);
        int s;
        if (p >= 0)
            return 0;
        s = -int'(p);
        if (s > CSIZE)
            s = CSIZE;
        return s;
    endfunction

    // Work out the memory rows caused by one source row and queue them
    task automatic predict_cursor_rows(input logic [ROW_W-1:0] src);
        int unsigned hs;
        int unsigned vs;
        int unsigned plane_row;
        bit          last_row;
        mem_row_t    batch[$];
        mem_row_t    item;
        hs = clip_amount(cur_x);
        vs = clip_amount(cur_y);
        if (hs >= CSIZE || vs >= CSIZE)
            vs = CSIZE;
        plane_row = (src_row_idx < CSIZE) ? src_row_idx : src_row_idx - CSIZE;
        last_row  = (plane_row == CSIZE - 1);
        if (plane_row >= vs)
        begin
            item.row       = (hs < ROW_W) ? (src << hs) : '0;
            item.run_end   = 1'b0;
            item.plane_end = 1'b0;
            batch.push_back(item);
        end
        if (last_row)
        begin
            for (int i = 0; i < vs; i++)
            begin
                item = '0;
                batch.push_back(item);
            end
        end
        if (batch.size() != 0)
        begin
            batch[batch.size()-1].run_end   = 1'b1;
            batch[batch.size()-1].plane_end = last_row;
        end
        foreach (batch[i])
            pending_rows.push_back(batch[i]);
        src_row_idx++;
        if (src_row_idx >= 2 * CSIZE)
            src_row_idx = 0;
    endtask

    // Offer one source word, with a random gap first, and hold it until taken
    task automatic send_row(input logic [ROW_W-1:0] src);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 40)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        row_bits <= src;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cursor_rows(src);
        rows_sent++;
    endtask

    // Drop valid and wait until every expected row is out and the back is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_POS_X)
            cur_x = val;
        else
            cur_y = val;
        @(posedge clk);
    endtask

    task automatic set_position(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        settle();
        write_reg(REG_POS_X, x);
        write_reg(REG_POS_Y, y);
    endtask

    function automatic logic [ROW_W-1:0] rand_row();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly small clips, with shifts around the full width and the extremes
    function automatic logic [POS_W-1:0] rand_pos();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = -int'($urandom_range(70));
            5:             v = -int'($urandom_range(63, 66));
            6:             v = $urandom_range(32767);
            7:             return POS_W'($urandom);
            8:             v = $urandom_range(1) ? -32768 : 32767;
            default:       v = 0;
        endcase
        return POS_W'(v);
    endfunction

    // Unclipped rows at the reset position, bit patterns at the extremes
    task automatic test_reset_position();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        send_row('0);
        send_row('1);
        send_row(64'h8000_0000_0000_0001);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_row(64'h5555_5555_5555_5555);
    endtask

    // Register extremes, dropped rows and the full shift
    task automatic test_position_extremes();
        set_position(16'sh8000, 16'sd0);
        send_row('1);
        send_row(64'h0123_4567_89AB_CDEF);
        set_position(16'sh7FFF, 16'sh7FFF);
        send_row('1);
        send_row(64'hFEDC_BA98_7654_3210);
        set_position(-16'sd1, 16'sd0);
        send_row('1);
        send_row(64'h8000_0000_0000_0001);
        set_position(-16'sd63, -16'sd1);
        send_row('1);
        send_row(64'h0000_0000_0000_0003);
        set_position(-16'sd64, 16'sd0);
        send_row('1);
        set_position(-16'sd32, 16'sh8000);
        send_row('1);
        set_position(16'sd0, -16'sd40);
        send_row('1);
        set_position(-16'sd65, -16'sd65);
        send_row('1);
    endtask

    // Random images in chunks, the position possibly rewritten between chunks
    task automatic test_random_images(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned quota);
        int unsigned stop_at;
        int unsigned len;
        src_idle_pct  = idle_pct;
        dst_stall_pct = stall_pct;
        stop_at       = rows_sent + quota;
        while (rows_sent < stop_at)
        begin
            settle();
            if ($urandom_range(3) != 0)
                write_reg(REG_POS_X, rand_pos());
            if ($urandom_range(3) != 0)
                write_reg(REG_POS_Y, rand_pos());
            len = $urandom_range(10, 70);
            if (len > stop_at - rows_sent)
                len = stop_at - rows_sent;
            repeat (len) send_row(rand_row());
        end
    endtask

    // Hold the receiver off for a long stretch while the source keeps offering
    task automatic test_backpressure();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        set_position(-16'sd5, -16'sd2);
        hold_req = 300;
        repeat (40) send_row(rand_row());
        // pause the source until everything has drained, then carry on
        settle();
        repeat (10) send_row(rand_row());
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_POS_X;
        wr_data       = '0;
        in_valid      = 1'b0;
        row_bits      = '0;
        out_stall     = 1'b0;
        cur_x         = '0;
        cur_y         = '0;
        src_row_idx   = 0;
        err_cnt       = 0;
        rows_sent     = 0;
        cycle_cnt     = 0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        hold_req      = 0;
        hold_left     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_position();
        test_position_extremes();
        test_random_images(0, 0, RANDOM_QUOTA);
        test_random_images(79, 0, RANDOM_QUOTA);
        test_backpressure();
        test_random_images(0, 79, RANDOM_QUOTA);
        test_random_images(37, 37, RANDOM_QUOTA);

        settle();
        repeat (20) @(posedge clk);
        if (pending_rows.size() != 0)
            report_mismatch("rows never written", ROW_W'(pending_rows.size()), '0);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/csl_pkg.sv
rtl/core/csl_front.sv
rtl/core/csl_queue.sv
rtl/core/csl_back.sv
rtl/core/cursor_image_clip_shift_loader.sv
verif/cursor_image_clip_shift_loader_tb.sv
